[rtl/activity_selection_greedy_core_macros.svh]
// Assertion macros for the activity selection core.
`ifndef ACTIVITY_SELECTION_GREEDY_CORE_MACROS_SVH
`define ACTIVITY_SELECTION_GREEDY_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge of clk, skipped while rst is high.
`define ASG_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check prop at every rising edge of clk, reset included.
`define ASG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASG_ASSERT_RST(lbl, clk, rst, prop, msg)
`define ASG_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/asg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package asg_pkg;

   localparam int MAX_ACTIVITIES_DEF = 64;
   localparam int TIME_BITS_DEF      = 16;
   localparam int TAG_BITS           = 16;
   localparam int IN_TIME_BITS       = 16;
   localparam int TIME_EXT_BITS      = 32;

   // per-cycle command to every cell of the chain
   typedef struct packed {
      logic insert;
      logic shift;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[rtl/asg_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module asg_cell
   import asg_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [TAG_BITS-1:0]  new_tag,
   input  wire logic [TIME_BITS-1:0] new_start,
   input  wire logic [TIME_BITS-1:0] new_finish,
   input  wire logic                 prev_keep,
   input  wire logic [TAG_BITS-1:0]  prev_tag,
   input  wire logic [TIME_BITS-1:0] prev_start,
   input  wire logic [TIME_BITS-1:0] prev_finish,
   input  wire logic                 prev_valid,
   input  wire logic                 next_valid,
   input  wire logic [TAG_BITS-1:0]  next_tag,
   input  wire logic [TIME_BITS-1:0] next_start,
   input  wire logic [TIME_BITS-1:0] next_finish,
   output logic                      keep,
   output logic                      cell_valid,
   output logic [TAG_BITS-1:0]       cell_tag,
   output logic [TIME_BITS-1:0]      cell_start,
   output logic [TIME_BITS-1:0]      cell_finish
);

   logic                 valid_ff,  valid_in;
   logic [TAG_BITS-1:0]  tag_ff,    tag_in;
   logic [TIME_BITS-1:0] start_ff,  start_in;
   logic [TIME_BITS-1:0] finish_ff, finish_in;

   // equal finish keeps the older entry in front
   assign keep = valid_ff && (finish_ff <= new_finish);

   always_comb begin
      valid_in  = valid_ff;
      tag_in    = tag_ff;
      start_in  = start_ff;
      finish_in = finish_ff;
      priority if (ctrl.shift) begin
         valid_in  = next_valid;
         tag_in    = next_tag;
         start_in  = next_start;
         finish_in = next_finish;
      end else if (ctrl.insert && !keep) begin
         if (prev_keep) begin
            valid_in  = 1'b1;
            tag_in    = new_tag;
            start_in  = new_start;
            finish_in = new_finish;
         end else begin
            valid_in  = prev_valid;
            tag_in    = prev_tag;
            start_in  = prev_start;
            finish_in = prev_finish;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff    <= tag_in;
      start_ff  <= start_in;
      finish_ff <= finish_in;
   end

   assign cell_valid  = valid_ff;
   assign cell_tag    = tag_ff;
   assign cell_start  = start_ff;
   assign cell_finish = finish_ff;

endmodule

`default_nettype wire

[rtl/asg_chain.sv]
`timescale 1ns / 1ps
`default_nettype none

module asg_chain
   import asg_pkg::*;
#(
   parameter int MAX_ACTIVITIES = MAX_ACTIVITIES_DEF,
   parameter int TIME_BITS      = TIME_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cell_ctrl_type        ctrl,
   input  wire logic [TAG_BITS-1:0]  new_tag,
   input  wire logic [TIME_BITS-1:0] new_start,
   input  wire logic [TIME_BITS-1:0] new_finish,
   output logic                      full,
   output logic                      head_valid,
   output logic [TAG_BITS-1:0]       head_tag,
   output logic [TIME_BITS-1:0]      head_start,
   output logic [TIME_BITS-1:0]      head_finish
);

   logic                 valid_w  [MAX_ACTIVITIES];
   logic                 keep_w   [MAX_ACTIVITIES];
   logic [TAG_BITS-1:0]  tag_w    [MAX_ACTIVITIES];
   logic [TIME_BITS-1:0] start_w  [MAX_ACTIVITIES];
   logic [TIME_BITS-1:0] finish_w [MAX_ACTIVITIES];

   for (genvar i = 0; i < MAX_ACTIVITIES; i++) begin : g_cell
      logic                 p_keep;
      logic                 p_valid;
      logic [TAG_BITS-1:0]  p_tag;
      logic [TIME_BITS-1:0] p_start;
      logic [TIME_BITS-1:0] p_finish;
      logic                 n_valid;
      logic [TAG_BITS-1:0]  n_tag;
      logic [TIME_BITS-1:0] n_start;
      logic [TIME_BITS-1:0] n_finish;

      if (i == 0) begin : g_first
         assign p_keep   = 1'b1;
         assign p_valid  = 1'b1;
         assign p_tag    = new_tag;
         assign p_start  = new_start;
         assign p_finish = new_finish;
      end else begin : g_mid
         assign p_keep   = keep_w[i-1];
         assign p_valid  = valid_w[i-1];
         assign p_tag    = tag_w[i-1];
         assign p_start  = start_w[i-1];
         assign p_finish = finish_w[i-1];
      end

      if (i == MAX_ACTIVITIES - 1) begin : g_last
         assign n_valid  = 1'b0;
         assign n_tag    = tag_w[i];
         assign n_start  = start_w[i];
         assign n_finish = finish_w[i];
      end else begin : g_inner
         assign n_valid  = valid_w[i+1];
         assign n_tag    = tag_w[i+1];
         assign n_start  = start_w[i+1];
         assign n_finish = finish_w[i+1];
      end

      asg_cell #(
         .TIME_BITS (TIME_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .new_tag     (new_tag),
         .new_start   (new_start),
         .new_finish  (new_finish),
         .prev_keep   (p_keep),
         .prev_tag    (p_tag),
         .prev_start  (p_start),
         .prev_finish (p_finish),
         .prev_valid  (p_valid),
         .next_valid  (n_valid),
         .next_tag    (n_tag),
         .next_start  (n_start),
         .next_finish (n_finish),
         .keep        (keep_w[i]),
         .cell_valid  (valid_w[i]),
         .cell_tag    (tag_w[i]),
         .cell_start  (start_w[i]),
         .cell_finish (finish_w[i])
      );
   end

   // entries pack from the front, so the last cell fills last
   assign full        = valid_w[MAX_ACTIVITIES-1];
   assign head_valid  = valid_w[0];
   assign head_tag    = tag_w[0];
   assign head_start  = start_w[0];
   assign head_finish = finish_w[0];

endmodule

`default_nettype wire

[rtl/activity_selection_greedy_core.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "activity_selection_greedy_core_macros.svh"

// Earliest-finish activity selection.
// Input channel: an activity transfers at a rising edge with start high and
// busy low; req_set_end marks the last activity of a set. Activities load one
// per cycle into a row of cells kept sorted by finish time (equal finish times
// stay in arrival order), so busy stays low while a set is loading.
// The set_end transfer starts the selection: busy rises and stays high until the
// chain has drained. Each cycle the head cell is examined and the chain shifts one
// place toward it; this one shift per cycle sets the pace.
// Result channel: each selected tag appears for one cycle with rsp_strobe high;
// picks are held back until the next pick or the drain so that rsp_run_end can
// mark the final one, which comes out in the first cycle after busy falls.
// The receiver cannot stall. A new set cannot load until the scan has finished.
// Once MAX_ACTIVITIES are held, further activities of the set are dropped and
// every result of that set carries rsp_overflowed.
// Reset empties the chain, returns to idle and clears the drop flag; no
// clearing pass is needed.
module activity_selection_greedy_core
   import asg_pkg::*;
#(
   parameter int MAX_ACTIVITIES = MAX_ACTIVITIES_DEF,
   parameter int TIME_BITS      = TIME_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [TAG_BITS-1:0]     req_activity_tag,
   input  wire logic [IN_TIME_BITS-1:0] req_start_time,
   input  wire logic [IN_TIME_BITS-1:0] req_finish_time,
   input  wire logic                    req_set_end,
   output logic                         rsp_strobe,
   output logic [TAG_BITS-1:0]          rsp_selected_tag,
   output logic                         rsp_run_end,
   output logic                         rsp_overflowed
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic                 drop_ff, drop_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [TAG_BITS-1:0]  pend_tag_ff, pend_tag_in;
   logic [TIME_BITS-1:0] last_finish_ff, last_finish_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [TAG_BITS-1:0]  rsp_tag_ff, rsp_tag_in;
   logic                 rsp_run_end_ff, rsp_run_end_in;
   logic                 rsp_overflowed_ff, rsp_overflowed_in;

   logic                     accept;
   logic                     full;
   logic                     head_valid;
   logic [TAG_BITS-1:0]      head_tag;
   logic [TIME_BITS-1:0]     head_start;
   logic [TIME_BITS-1:0]     head_finish;
   logic                     take_head;
   cell_ctrl_type            ctrl;
   logic [TIME_EXT_BITS-1:0] start_ext;
   logic [TIME_EXT_BITS-1:0] finish_ext;
   logic [TIME_BITS-1:0]     new_start;
   logic [TIME_BITS-1:0]     new_finish;

   assign busy   = (state_ff == ST_SCAN);
   assign accept = start && !busy;

   // times compare in their low TIME_BITS bits
   assign start_ext  = {{(TIME_EXT_BITS-IN_TIME_BITS){1'b0}}, req_start_time};
   assign finish_ext = {{(TIME_EXT_BITS-IN_TIME_BITS){1'b0}}, req_finish_time};
   assign new_start  = start_ext[TIME_BITS-1:0];
   assign new_finish = finish_ext[TIME_BITS-1:0];

   // insert unless full; advance the chain one place per scan step
   assign ctrl.insert = accept && !full;
   assign ctrl.shift  = (state_ff == ST_SCAN) && head_valid;

   asg_chain #(
      .MAX_ACTIVITIES (MAX_ACTIVITIES),
      .TIME_BITS      (TIME_BITS)
   ) u_chain (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .new_tag     (req_activity_tag),
      .new_start   (new_start),
      .new_finish  (new_finish),
      .full        (full),
      .head_valid  (head_valid),
      .head_tag    (head_tag),
      .head_start  (head_start),
      .head_finish (head_finish)
   );

   // first activity always taken, then any that starts at or after the last finish
   assign take_head = head_valid && (!pend_valid_ff || (head_start >= last_finish_ff));

   always_comb begin
      state_in          = state_ff;
      drop_in           = drop_ff;
      pend_valid_in     = pend_valid_ff;
      pend_tag_in       = pend_tag_ff;
      last_finish_in    = last_finish_ff;
      rsp_strobe_in     = 1'b0;
      rsp_tag_in        = rsp_tag_ff;
      rsp_run_end_in    = 1'b0;
      rsp_overflowed_in = rsp_overflowed_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (full) begin
                  drop_in = 1'b1;
               end
               if (req_set_end) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (head_valid) begin
               if (take_head) begin
                  // release the previous pick, hold the new one back
                  rsp_strobe_in     = pend_valid_ff;
                  rsp_tag_in        = pend_tag_ff;
                  rsp_overflowed_in = drop_ff;
                  pend_valid_in     = 1'b1;
                  pend_tag_in       = head_tag;
                  last_finish_in    = head_finish;
               end
            end else begin
               // chain drained: the held pick is the final result
               rsp_strobe_in     = pend_valid_ff;
               rsp_tag_in        = pend_tag_ff;
               rsp_run_end_in    = 1'b1;
               rsp_overflowed_in = drop_ff;
               pend_valid_in     = 1'b0;
               drop_in           = 1'b0;
               state_in          = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         drop_ff        <= 1'b0;
         pend_valid_ff  <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         rsp_run_end_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         drop_ff        <= drop_in;
         pend_valid_ff  <= pend_valid_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         rsp_run_end_ff <= rsp_run_end_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_tag_ff       <= pend_tag_in;
      last_finish_ff    <= last_finish_in;
      rsp_tag_ff        <= rsp_tag_in;
      rsp_overflowed_ff <= rsp_overflowed_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_selected_tag = rsp_tag_ff;
   assign rsp_run_end      = rsp_strobe_ff && rsp_run_end_ff;
   assign rsp_overflowed   = rsp_overflowed_ff;

   `ASG_ASSERT_RST(a_set_end_busy, clock, reset, accept && req_set_end |=> busy, "set_end transfer did not start selection")
   `ASG_ASSERT_RST(a_final_idle, clock, reset, rsp_strobe && rsp_run_end |-> state_ff == ST_IDLE, "final result while still scanning")
   `ASG_ASSERT_RST(a_mid_in_scan, clock, reset, rsp_strobe && !rsp_run_end |-> state_ff == ST_SCAN, "non-final result outside a scan")
   `ASG_ASSERT_RST(a_pick_before_end, clock, reset, (state_ff == ST_SCAN) && !head_valid |-> pend_valid_ff, "scan ended with no activity selected")
   `ASG_ASSERT_ALWAYS(a_reset_quiet, clock, $past(reset) |-> !rsp_strobe, "result right after reset")

endmodule

`default_nettype wire
